[hdl/mqt_pkg.sv]
// shared constants, types and op codes for the majority quorum tracker
package mqt_pkg;

    localparam int SLOTS     = 256;
    localparam int ACCEPTORS = 16;
    localparam int TABLES    = 2;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ID_W    = $clog2(ACCEPTORS);
    localparam int NUM_W   = 5;
    localparam int ADDR_W  = $clog2(TABLES * SLOTS);
    localparam int DEPTH   = TABLES * SLOTS;
    localparam int CNT_W   = $clog2(ACCEPTORS + 1);

    localparam logic [NUM_W-1:0] NUM_ACC_RESET = NUM_W'(3);
    localparam logic [NUM_W-1:0] NUM_ACC_MAX   = NUM_W'(ACCEPTORS);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef logic [ACCEPTORS-1:0] vote_row_t;

    typedef struct packed {
        logic quorum_reached;
        logic acceptor_present;
    } flags_t;

endpackage

[hdl/mqt_channels.sv]
// valid/ready channel interfaces for items, results and configuration
interface mqt_cmd_if
    import mqt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic              table_sel;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   voter_id;

    modport source (output valid, op, table_sel, slot, voter_id, input ready);
    modport sink   (input valid, op, table_sel, slot, voter_id, output ready);
endinterface

interface mqt_rsp_if;
    logic valid;
    logic ready;
    logic quorum_reached;
    logic acceptor_present;

    modport source (output valid, quorum_reached, acceptor_present, input ready);
    modport sink   (input valid, quorum_reached, acceptor_present, output ready);
endinterface

interface mqt_cfg_if
    import mqt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hdl/mqt_row_update.sv]
// applies one operation to a vote row and derives the quorum and presence flags
module mqt_row_update
    import mqt_pkg::*;
(
    input  vote_row_t        row_in,
    input  logic [1:0]       op,
    input  logic [ID_W-1:0]  voter_id,
    input  logic [NUM_W-1:0] n_use,
    output vote_row_t        row_out,
    output flags_t           flags
);

    vote_row_t        use_mask;
    vote_row_t        id_bit;
    logic [CNT_W-1:0] vote_cnt;

    assign use_mask = ACCEPTORS'((({{ACCEPTORS{1'b0}}, 1'b1}) << n_use) - 1'b1);
    assign id_bit   = ACCEPTORS'(1) << voter_id;

    always_comb
    begin
        case (op)
            OP_CLEAR: row_out = '0;
            OP_ADD:   row_out = ({1'b0, voter_id} < n_use) ? (row_in | id_bit) : row_in;
            OP_QUERY: row_out = row_in;
            default:  row_out = row_in;
        endcase
    end

    assign vote_cnt               = CNT_W'($countones(row_out & use_mask));
    assign flags.quorum_reached   = ({1'b0, vote_cnt, 1'b0} > (CNT_W + 2)'(n_use));
    assign flags.acceptor_present = row_out[voter_id];

endmodule

[hdl/majority_quorum_tracker.sv]
// top level: vote table memory, read-modify-write pipeline and result register
//
//  channel | role   | payload
//  --------+--------+-------------------------------------------------
//  cmd     | sink   | op, table_sel, slot, voter_id
//  rsp     | source | quorum_reached, acceptor_present
//  cfg     | sink   | data = num_acceptors
//
// one item per cycle while rsp does not stall: read at accept, modify and write back when the stage advances
// both tables share one 512-row memory with a registered read port
// a write landing in the same cycle as the read of that row is forwarded
// after reset a clearing pass zeroes all 512 rows of the memory; cmd.ready is low meanwhile
// a stalled rsp holds the pipeline stage, which then holds cmd.ready low
module majority_quorum_tracker
    import mqt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    mqt_cmd_if.sink cmd,
    mqt_rsp_if.source rsp,
    mqt_cfg_if.sink cfg
);

    vote_row_t         vote_mem [DEPTH];
    vote_row_t         rdata_reg;

    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NUM_W-1:0]  num_acc_reg, num_acc_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              out_valid_reg, out_valid_next;

    logic [ADDR_W-1:0] s1_addr_reg;
    logic [1:0]        s1_op_reg;
    logic [ID_W-1:0]   s1_id_reg;
    logic              fwd_hit_reg;
    vote_row_t         fwd_data_reg;
    flags_t            out_flags_reg;

    logic              accept;
    logic              s1_adv;
    logic [ADDR_W-1:0] in_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    vote_row_t         mem_wdata;
    vote_row_t         row_cur;
    vote_row_t         row_new;
    flags_t            flags_new;
    logic [NUM_W-1:0]  n_use;

    assign n_use   = (num_acc_reg > NUM_ACC_MAX) ? NUM_ACC_MAX : num_acc_reg;
    assign in_addr = {cmd.table_sel, cmd.slot};

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign accept    = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign row_cur = fwd_hit_reg ? fwd_data_reg : rdata_reg;

    mqt_row_update u_row_update (
        .row_in   (row_cur),
        .op       (s1_op_reg),
        .voter_id (s1_id_reg),
        .n_use    (n_use),
        .row_out  (row_new),
        .flags    (flags_new)
    );

    assign mem_we    = clr_busy_reg || s1_adv;
    assign mem_waddr = clr_busy_reg ? clr_cnt_reg : s1_addr_reg;
    assign mem_wdata = clr_busy_reg ? '0 : row_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vote_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rdata_reg <= vote_mem[in_addr];
        end
    end

    always_comb
    begin
        clr_busy_next  = clr_busy_reg;
        clr_cnt_next   = clr_cnt_reg;
        num_acc_next   = num_acc_reg;
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;

        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end

        if (cfg.valid)
        begin
            num_acc_next = cfg.data;
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            num_acc_reg   <= NUM_ACC_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            num_acc_reg   <= num_acc_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage payload and forwarding of a write that lands on the read edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= in_addr;
            s1_op_reg    <= cmd.op;
            s1_id_reg    <= cmd.voter_id;
            fwd_hit_reg  <= s1_adv && (s1_addr_reg == in_addr);
            fwd_data_reg <= row_new;
        end
        if (s1_adv)
        begin
            out_flags_reg <= flags_new;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.quorum_reached   = out_flags_reg.quorum_reached;
    assign rsp.acceptor_present = out_flags_reg.acceptor_present;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !cmd.ready)
        else $error("item accepted during clearing pass");

    a_write_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && !clr_busy_reg) |-> s1_valid_reg)
        else $error("row written back with no item in flight");

    a_rsp_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && !s1_adv) |=> !rsp.valid)
        else $error("result repeated after it was taken");

    a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item lost before write-back");

endmodule
